// ===== rtl/core/glu_pkg.sv =====
// ---------------------------------------------------------------------------
// glu_pkg : shared types and constants of the GCD / LCM unit
// Operand width, queue depth, the queued item and the back-end states.
// ---------------------------------------------------------------------------
`default_nettype none

package glu_pkg;

	// operand width actually used; bits above it are ignored
	localparam int WIDTH = 32;

	// fixed field widths of the stream payload
	localparam int IN_FIELD_W = 32;
	localparam int GCD_OUT_W  = 32;
	localparam int LCM_OUT_W  = 64;
	localparam int S_DATA_W   = 2 * IN_FIELD_W;
	localparam int M_DATA_W   = GCD_OUT_W + LCM_OUT_W;

	// derived internal widths
	localparam int PROD_W = 2 * WIDTH;
	localparam int K_W    = $clog2(WIDTH);
	localparam int CNT_W  = $clog2(WIDTH + 1);

	// front-to-back queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [WIDTH-1:0] a;
		logic [WIDTH-1:0] b;
		logic             zero_err;
	} glu_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_GCD,
		BK_DIV,
		BK_MUL,
		BK_DONE
	} glu_bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/gcd_lcm_unit.sv =====
// Path: the input stage, the queue, a load into the engine, the binary-GCD steps,
//   the restoring division steps, the multiply and the output register; a zero
//   operand goes from the load straight to the output register.
// Throughput: one item per back-end run, set by the GCD loop and the divider.
// Reset: arst_n clears all control state at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
// gcd_lcm_unit : GCD and LCM of two unsigned integers
// Front stage classifies beats, a short queue decouples it from the engine.
// ---------------------------------------------------------------------------
`default_nettype none

module gcd_lcm_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input beat
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [glu_pkg::S_DATA_W-1:0] s_axis_tdata,  // operand_a, operand_b
	// result beat
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [glu_pkg::M_DATA_W-1:0]      m_axis_tdata,  // gcd_value, lcm_value
	output logic [0:0]                        m_axis_tuser   // zero_operand_error
);

	logic               f_valid;
	logic               f_ready;
	glu_pkg::glu_item_t f_item;
	logic               q_valid;
	logic               q_ready;
	glu_pkg::glu_item_t q_item;

	logic [glu_pkg::GCD_OUT_W-1:0] gcd_v;
	logic [glu_pkg::LCM_OUT_W-1:0] lcm_v;
	logic                          err_v;

	// front: mask to WIDTH, flag zero operands
	glu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_a       (s_axis_tdata[glu_pkg::IN_FIELD_W-1:0]),
		.in_b       (s_axis_tdata[glu_pkg::S_DATA_W-1:glu_pkg::IN_FIELD_W]),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	// lets the front keep taking beats while the engine grinds
	glu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// back: GCD loop, divider, multiplier, output register
	glu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_gcd    (gcd_v),
		.out_lcm    (lcm_v),
		.out_err    (err_v)
	);

	assign m_axis_tdata = {lcm_v, gcd_v};
	assign m_axis_tuser = err_v;

endmodule

`default_nettype wire

// ===== rtl/core/glu_front.sv =====
// ---------------------------------------------------------------------------
// glu_front : input stage
// Takes operand beats, masks them to WIDTH and flags a zero operand.
// ---------------------------------------------------------------------------
`default_nettype none

module glu_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [glu_pkg::IN_FIELD_W-1:0] in_a,
	input  wire logic [glu_pkg::IN_FIELD_W-1:0] in_b,
	output logic                                item_valid,
	input  wire logic                           item_ready,
	output glu_pkg::glu_item_t                  item
);

	logic               valid_s1;
	glu_pkg::glu_item_t item_s1;
	logic [glu_pkg::WIDTH-1:0] a_m;
	logic [glu_pkg::WIDTH-1:0] b_m;

	assign a_m = in_a[glu_pkg::WIDTH-1:0];
	assign b_m = in_b[glu_pkg::WIDTH-1:0];

	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.a        <= a_m;
			item_s1.b        <= b_m;
			item_s1.zero_err <= (a_m == '0) || (b_m == '0);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/glu_queue.sv =====
// ---------------------------------------------------------------------------
// glu_queue : short queue between front and back
// Small register FIFO of classified items.
// ---------------------------------------------------------------------------
`default_nettype none

module glu_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire glu_pkg::glu_item_t push_item,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output glu_pkg::glu_item_t pop_item
);

	glu_pkg::glu_item_t              mem_q [glu_pkg::QDEPTH];
	logic [glu_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [glu_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [glu_pkg::QCNT_W-1:0]      cnt_q;
	logic                            push;
	logic                            pop;

	assign push_ready = (cnt_q != glu_pkg::QCNT_W'(glu_pkg::QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == glu_pkg::QPTR_W'(glu_pkg::QDEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == glu_pkg::QPTR_W'(glu_pkg::QDEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/glu_back.sv =====
// ---------------------------------------------------------------------------
// glu_back : execution engine
// Binary GCD, restoring division a/g, one multiply, output register.
// ---------------------------------------------------------------------------
`default_nettype none

module glu_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire glu_pkg::glu_item_t            item,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [glu_pkg::GCD_OUT_W-1:0]      out_gcd,
	output logic [glu_pkg::LCM_OUT_W-1:0]      out_lcm,
	output logic                               out_err
);

	localparam int W = glu_pkg::WIDTH;

	glu_pkg::glu_bk_state_t state_q, state_d;

	// control strobes
	logic load;
	logic gcd_done;
	logic div_last;
	logic out_load;

	// datapath
	logic [W-1:0]              a_orig_q;
	logic [W-1:0]              b_orig_q;
	logic [W-1:0]              ga_q;
	logic [W-1:0]              gb_q;
	logic [glu_pkg::K_W-1:0]   k_q;
	logic                      err_q;
	logic [W-1:0]              g_q;
	logic [W-1:0]              div_q;
	logic [W-1:0]              rem_q;
	logic [glu_pkg::CNT_W-1:0] cnt_q;
	logic [glu_pkg::PROD_W-1:0] prod_q;
	logic [W:0]                rem_shift;
	logic                      rem_ge;
	logic [glu_pkg::PROD_W-1:0] prod_w;

	logic                           out_valid_q;
	logic [glu_pkg::GCD_OUT_W-1:0]  out_gcd_q;
	logic [glu_pkg::LCM_OUT_W-1:0]  out_lcm_q;
	logic                           out_err_q;

	assign rem_shift = {rem_q, div_q[W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, g_q});
	assign prod_w    = glu_pkg::PROD_W'(div_q) * glu_pkg::PROD_W'(b_orig_q);

	// strobes
	always_comb begin
		load     = 1'b0;
		gcd_done = 1'b0;
		div_last = 1'b0;
		out_load = 1'b0;
		case (state_q)
			glu_pkg::BK_IDLE: load     = item_valid;
			glu_pkg::BK_GCD:  gcd_done = (ga_q == gb_q);
			glu_pkg::BK_DIV:  div_last = (cnt_q == glu_pkg::CNT_W'(1));
			glu_pkg::BK_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign item_ready = load;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			glu_pkg::BK_IDLE: if (load) begin
				state_d = item.zero_err ? glu_pkg::BK_DONE : glu_pkg::BK_GCD;
			end
			glu_pkg::BK_GCD:  if (gcd_done) state_d = glu_pkg::BK_DIV;
			glu_pkg::BK_DIV:  if (div_last) state_d = glu_pkg::BK_MUL;
			glu_pkg::BK_MUL:  state_d = glu_pkg::BK_DONE;
			glu_pkg::BK_DONE: if (out_load) state_d = glu_pkg::BK_IDLE;
			default:          state_d = glu_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= glu_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_orig_q <= item.a;
			b_orig_q <= item.b;
			ga_q     <= item.a;
			gb_q     <= item.b;
			k_q      <= '0;
			err_q    <= item.zero_err;
		end
		if (state_q == glu_pkg::BK_GCD) begin
			if (gcd_done) begin
				g_q   <= ga_q << k_q;
				div_q <= a_orig_q;
				rem_q <= '0;
				cnt_q <= glu_pkg::CNT_W'(W);
			end else if (!ga_q[0] && !gb_q[0]) begin
				ga_q <= ga_q >> 1;
				gb_q <= gb_q >> 1;
				k_q  <= k_q + 1'b1;
			end else if (!ga_q[0]) begin
				ga_q <= ga_q >> 1;
			end else if (!gb_q[0]) begin
				gb_q <= gb_q >> 1;
			end else if (ga_q > gb_q) begin
				// odd minus odd is even, so the halving is exact
				ga_q <= (ga_q - gb_q) >> 1;
			end else begin
				gb_q <= (gb_q - ga_q) >> 1;
			end
		end
		if (state_q == glu_pkg::BK_DIV) begin
			// quotient bits shift in behind the dividend
			rem_q <= rem_ge ? W'(rem_shift - {1'b0, g_q}) : rem_shift[W-1:0];
			div_q <= {div_q[W-2:0], rem_ge};
			cnt_q <= cnt_q - 1'b1;
		end
		if (state_q == glu_pkg::BK_MUL) begin
			prod_q <= prod_w;
		end
		if (out_load) begin
			out_err_q <= err_q;
			out_gcd_q <= err_q ? '0 : glu_pkg::GCD_OUT_W'(g_q);
			out_lcm_q <= err_q ? '0 : glu_pkg::LCM_OUT_W'(prod_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_gcd   = out_gcd_q;
	assign out_lcm   = out_lcm_q;
	assign out_err   = out_err_q;

endmodule

`default_nettype wire

// ===== rtl/core/glu_chk.sv =====
// ---------------------------------------------------------------------------
// glu_chk : port checker for gcd_lcm_unit
// Result beat rules seen at the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none

module glu_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         m_axis_tvalid,
	input wire logic                         m_axis_tready,
	input wire logic [glu_pkg::M_DATA_W-1:0] m_axis_tdata,
	input wire logic [0:0]                   m_axis_tuser
);

	// stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	// stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result payload changed while stalled");

	// error beats carry zero results
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("error beat with nonzero result");

	// good beats never carry a zero GCD or LCM
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
			m_axis_tdata[glu_pkg::GCD_OUT_W-1:0] != '0 &&
			m_axis_tdata[glu_pkg::M_DATA_W-1:glu_pkg::GCD_OUT_W] != '0)
		else $error("zero result without error flag");

endmodule

bind gcd_lcm_unit glu_chk u_glu_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb : self-checking bench for gcd_lcm_unit
// Streams operand pairs in bursts and checks each result beat against a
// Euclid-based GCD / LCM prediction. The result side stalls on its own
// pattern, with one long hold-off that backs the unit up.
// ---------------------------------------------------------------------------

// holds predicted GCD / LCM results in arrival order and checks result beats
class gcd_lcm_scoreboard;
	typedef struct {
		bit [31:0] gcd;
		bit [63:0] lcm;
		bit        zero_err;
	} gcd_lcm_t;

	gcd_lcm_t pending_results[$];
	int       mismatches;
	int       results_checked;
	int       zero_results;

	// GCD by Euclid on the masked operands, LCM at double width
	function gcd_lcm_t compute_gcd_lcm(bit [31:0] a_in, bit [31:0] b_in);
		gcd_lcm_t  res;
		bit [63:0] mask;
		bit [63:0] x;
		bit [63:0] y;
		bit [63:0] r;
		bit [63:0] a_m;
		bit [63:0] b_m;
		mask = (64'd1 << glu_pkg::WIDTH) - 64'd1;
		a_m  = {32'd0, a_in} & mask;
		b_m  = {32'd0, b_in} & mask;
		if (a_m == 0 || b_m == 0) begin
			res.gcd      = '0;
			res.lcm      = '0;
			res.zero_err = 1'b1;
			return res;
		end
		x = a_m;
		y = b_m;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		res.gcd      = x[31:0];
		res.lcm      = (a_m / x) * b_m;
		res.zero_err = 1'b0;
		return res;
	endfunction

	function void note_operands(bit [31:0] a_in, bit [31:0] b_in);
		pending_results.push_back(compute_gcd_lcm(a_in, b_in));
	endfunction

	task report(string what, bit [63:0] want, bit [63:0] got);
		mismatches++;
		// keep the log bounded if the unit is badly broken
		if (mismatches <= 40)
			$display("tb: mismatch on %s at %0t: expected %0h, got %0h",
				what, $realtime, want, got);
	endtask

	task check_result(bit [31:0] gcd, bit [63:0] lcm, bit zero_err);
		gcd_lcm_t want;
		if (pending_results.size() == 0) begin
			report("unexpected result beat", 64'd0, {32'd0, gcd});
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		if (want.zero_err)
			zero_results++;
		if (gcd !== want.gcd)
			report("gcd_value", {32'd0, want.gcd}, {32'd0, gcd});
		if (lcm !== want.lcm)
			report("lcm_value", want.lcm, lcm);
		if (zero_err !== want.zero_err)
			report("zero_operand_error", {63'd0, want.zero_err}, {63'd0, zero_err});
	endtask
endclass

module tb;
	localparam int RANDOM_ITEMS  = 830;
	localparam int HOLD_CYCLES   = 600;      // long receiver hold-off
	localparam int HOLD_AFTER    = 60;       // input beats before the hold-off
	localparam int WATCHDOG      = 4000;     // cycles with no beat on either side
	localparam int MAX_LATENCY   = 3 * glu_pkg::WIDTH + 5;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [glu_pkg::S_DATA_W-1:0] s_axis_tdata = '0;   // operand_a, operand_b
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [glu_pkg::M_DATA_W-1:0] m_axis_tdata;        // gcd_value, lcm_value
	logic [0:0]                   m_axis_tuser;        // zero_operand_error

	gcd_lcm_scoreboard sb = new();

	int  beats_in;
	int  idle_cycles;
	bit  hold_off_done;

	gcd_lcm_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// ---- input beat monitor: every accepted operand pair gets a prediction
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			sb.note_operands(s_axis_tdata[31:0], s_axis_tdata[63:32]);
			beats_in++;
		end
	end

	// ---- result beat monitor: gcd in the low word, lcm above it
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[glu_pkg::GCD_OUT_W-1:0],
				m_axis_tdata[glu_pkg::M_DATA_W-1:glu_pkg::GCD_OUT_W],
				m_axis_tuser[0]);
	end

	// ---- watchdog: ends the run if neither side moves a beat for too long
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb: watchdog expired with %0d results outstanding",
			sb.pending_results.size());
		$display("tb: done, errors");
		$finish;
	end

	// ---- result side: segments of differing stall behaviour, one long hold-off
	initial begin
		int mode;
		int seg_len;
		int phase;
		@(posedge arst_n);
		forever begin
			if (!hold_off_done && beats_in >= HOLD_AFTER) begin
				// input keeps offering meanwhile, so queue and engine fill and
				// tready on the input side has to drop
				repeat (HOLD_CYCLES) begin
					@(posedge clk);
					m_axis_tready <= 1'b0;
				end
				hold_off_done = 1'b1;
			end
			mode    = $urandom_range(0, 3);
			seg_len = $urandom_range(8, 200);
			phase   = 0;
			repeat (seg_len) begin
				@(posedge clk);
				case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= phase[1];
				endcase
				phase++;
			end
		end
	end

	// ---- stimulus helpers; each is entered right after a rising edge

	task automatic send_operands(bit [31:0] a_in, bit [31:0] b_in);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b_in, a_in};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// drops tvalid and scrambles tdata so the unit must ignore idle data
	task automatic input_gap(int cycles);
		if (cycles > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= {$urandom, $urandom};
			repeat (cycles) @(posedge clk);
		end
	endtask

	// mix of operand shapes: plain random, shared factors, small, zero, multiples, shifted odds
	task automatic pick_operands(output bit [31:0] a_out, output bit [31:0] b_out);
		int        kind;
		bit [31:0] g;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			a_out = $urandom;
			b_out = $urandom;
		end else if (kind < 60) begin
			g     = $urandom_range(1, (32'd1 << $urandom_range(1, 20)) - 1);
			a_out = g * $urandom_range(1, 32'hFFFF_FFFF / g);
			b_out = g * $urandom_range(1, 32'hFFFF_FFFF / g);
		end else if (kind < 70) begin
			a_out = $urandom_range(1, 255);
			b_out = $urandom_range(1, 255);
		end else if (kind < 78) begin
			a_out = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
			b_out = (a_out == 0 && $urandom_range(0, 1)) ? $urandom : 32'd0;
		end else if (kind < 88) begin
			// one operand a multiple of the other, equal included
			b_out = $urandom_range(1, 65535);
			a_out = b_out * $urandom_range(1, 32'hFFFF_FFFF / b_out);
			if ($urandom_range(0, 1))
				{a_out, b_out} = {b_out, a_out};
		end else begin
			// powers of two times odd numbers exercise the shift steps
			a_out = ($urandom | 32'd1) << $urandom_range(0, 31);
			b_out = ($urandom | 32'd1) << $urandom_range(0, 31);
		end
	endtask

	// ---- main sequence
	initial begin
		bit [31:0] dir_a[$];
		bit [31:0] dir_b[$];
		bit [31:0] a_val;
		bit [31:0] b_val;
		int        sent;
		int        burst;

		dir_a = {32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'd12345, 32'd48, 32'd18, 32'd1836311903, 32'd2971215073,
			32'd4294967291, 32'hAAAA_AAAA, 32'hFFFF_0000, 32'd3, 32'h0001_0000};
		dir_b = {32'd0, 32'd1, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1,
			32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h0001_0000, 32'd1,
			32'd12345, 32'd18, 32'd48, 32'd1134903170, 32'd1836311903,
			32'd4294967279, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0001_0000};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero operands, extremes, equal operands, Fibonacci worst case,
		// large coprimes whose LCM nearly fills 64 bits
		foreach (dir_a[i]) begin
			send_operands(dir_a[i], dir_b[i]);
			input_gap(($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && sent < RANDOM_ITEMS) begin
				pick_operands(a_val, b_val);
				send_operands(a_val, b_val);
				burst--;
				sent++;
			end
			input_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150));
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * MAX_LATENCY) @(posedge clk);

		$display("tb: %0d operand beats sent, %0d results checked (%0d zero-operand)",
			beats_in, sb.results_checked, sb.zero_results);
		$display("tb: receiver held off for %0d cycles once, %0d mismatches",
			HOLD_CYCLES, sb.mismatches);
		if (sb.mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
